// ===== sv/trapezoid_motion_profile_macros.svh =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_macros.svh
// Assertion macros shared by the trapezoid profile RTL.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOID_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOID_MOTION_PROFILE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TMP_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TMP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TMP_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define TMP_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== sv/tmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmp_pkg
// Types and constants of the trapezoid motion profile.
// ----------------------------------------------------------------------------
package tmp_pkg;

   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VELOCITY = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_TICKS   = 4'd1;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic [30:0] MAX_VELOCITY_RESET = 31'd65536;
   localparam logic [15:0] RAMP_TICKS_RESET   = 16'd100;

   localparam logic [5:0] MUL_LAST  = 6'd32;
   localparam logic [5:0] DIV_LAST  = 6'd48;
   localparam logic [5:0] SQRT_LAST = 6'd24;

   localparam logic [40:0] DELTA_CLAMP = 41'h10000000000;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_ACCEL,
      STEP_TRI_Q,
      STEP_TRI_ROOT,
      STEP_TRI_PEAK,
      STEP_CRUISE,
      STEP_VEL,
      STEP_DELTA
   } step_type;

   typedef enum logic [1:0] {
      REGION_RAMP,
      REGION_CRUISE,
      REGION_DECEL,
      REGION_OVER
   } region_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ACCEL,
      S_TRI_Q,
      S_TRI_ROOT,
      S_TRI_PEAK,
      S_CRUISE,
      S_TICK,
      S_VEL,
      S_DELTA,
      S_OUT
   } state_type;

   typedef struct packed {
      logic     load;
      step_type step;
      logic     set_static;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic       iter_done;
      logic       is_start;
      logic       triangular;
      region_type region;
   } status_type;

endpackage

// ===== sv/tmp_req_if.sv =====
// ----------------------------------------------------------------------------
// tmp_req_if
// Request channel: start-move and tick words.
// ----------------------------------------------------------------------------
interface tmp_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [31:0] goal_position;
   logic signed [31:0] start_position;
   logic [31:0]        elapsed_ticks;

   modport source (output valid, operation, goal_position, start_position, elapsed_ticks,
                   input ready);
   modport sink (input valid, operation, goal_position, start_position, elapsed_ticks,
                 output ready);
endinterface

// ===== sv/tmp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tmp_rsp_if
// Response channel: setpoint words.
// ----------------------------------------------------------------------------
interface tmp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] setpoint_position;
   logic [30:0]        setpoint_velocity;
   logic signed [47:0] setpoint_accel;
   logic               profile_done;

   modport source (output valid, setpoint_position, setpoint_velocity, setpoint_accel,
                   profile_done, input ready);
   modport sink (input valid, setpoint_position, setpoint_velocity, setpoint_accel,
                 profile_done, output ready);
endinterface

// ===== sv/tmp_csr_if.sv =====
// ----------------------------------------------------------------------------
// tmp_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface tmp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tmp_pkg::CSR_IDX_W-1:0]    index;
   logic [tmp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/tmp_iter.sv =====
// ----------------------------------------------------------------------------
// tmp_iter
// Shared iterative unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module tmp_iter (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tmp_pkg::alu_op_type op,
   input  logic [46:0]         opa,
   input  logic [48:0]         opb,
   output logic                done,
   output logic [80:0]         result
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          cnt_ff, cnt_in;
   tmp_pkg::alu_op_type op_ff, op_in;
   logic [80:0]         acc_ff, acc_in;
   logic [80:0]         sh_ff, sh_in;
   logic [49:0]         nb_ff, nb_in;

   logic [5:0]          last;
   logic [48:0]         div_trial;
   logic                div_ge;
   logic [49:0]         sq_rem;
   logic [49:0]         sq_trial;
   logic                sq_ge;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      acc_in    = acc_ff;
      sh_in     = sh_ff;
      nb_in     = nb_ff;
      div_trial = {acc_ff[47:0], nb_ff[48]};
      div_ge    = div_trial >= {2'b00, sh_ff[46:0]};
      sq_rem    = {acc_ff[47:0], nb_ff[49:48]};
      sq_trial  = {sh_ff[47:0], 2'b01};
      sq_ge     = sq_rem >= sq_trial;
      case (op_ff)
         tmp_pkg::ALU_DIV:  last = tmp_pkg::DIV_LAST;
         tmp_pkg::ALU_SQRT: last = tmp_pkg::SQRT_LAST;
         default:           last = tmp_pkg::MUL_LAST;
      endcase
      if (!busy_ff) begin
         if (start && !done_ff) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            op_in   = op;
            acc_in  = '0;
            sh_in   = (op == tmp_pkg::ALU_SQRT) ? 81'd0 : {34'd0, opa};
            nb_in   = {1'b0, opb};
         end
      end else begin
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         case (op_ff)
            tmp_pkg::ALU_DIV: begin
               if (div_ge) begin
                  acc_in = {32'd0, div_trial - {2'b00, sh_ff[46:0]}};
                  nb_in  = {nb_ff[48:0], 1'b1};
               end else begin
                  acc_in = {32'd0, div_trial};
                  nb_in  = {nb_ff[48:0], 1'b0};
               end
            end
            tmp_pkg::ALU_SQRT: begin
               if (sq_ge) begin
                  acc_in = {31'd0, sq_rem - sq_trial};
                  sh_in  = {sh_ff[79:0], 1'b1};
               end else begin
                  acc_in = {31'd0, sq_rem};
                  sh_in  = {sh_ff[79:0], 1'b0};
               end
               nb_in = {nb_ff[47:0], 2'b00};
            end
            default: begin
               if (nb_ff[0]) begin
                  acc_in = acc_ff + sh_ff;
               end
               sh_in = {sh_ff[79:0], 1'b0};
               nb_in = {1'b0, nb_ff[49:1]};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= tmp_pkg::ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      nb_ff  <= nb_in;
   end

   always_comb begin
      case (op_ff)
         tmp_pkg::ALU_DIV:  result = {32'd0, nb_ff[48:0]};
         tmp_pkg::ALU_SQRT: result = sh_ff;
         default:           result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// ===== sv/tmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmp_ctrl
// Sequencer for start-move and tick words.
// ----------------------------------------------------------------------------
module tmp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  tmp_pkg::status_type status,
   output tmp_pkg::cmd_type    cmd
);

   tmp_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tmp_pkg::S_IDLE:     if (req_valid) state_in = tmp_pkg::S_DECODE;
         tmp_pkg::S_DECODE:   state_in = status.is_start ? tmp_pkg::S_ACCEL : tmp_pkg::S_TICK;
         tmp_pkg::S_ACCEL: begin
            if (status.iter_done) begin
               state_in = status.triangular ? tmp_pkg::S_TRI_Q : tmp_pkg::S_CRUISE;
            end
         end
         tmp_pkg::S_TRI_Q:    if (status.iter_done) state_in = tmp_pkg::S_TRI_ROOT;
         tmp_pkg::S_TRI_ROOT: if (status.iter_done) state_in = tmp_pkg::S_TRI_PEAK;
         tmp_pkg::S_TRI_PEAK: if (status.iter_done) state_in = tmp_pkg::S_OUT;
         tmp_pkg::S_CRUISE:   if (status.iter_done) state_in = tmp_pkg::S_OUT;
         tmp_pkg::S_TICK: begin
            if (status.region == tmp_pkg::REGION_RAMP ||
                status.region == tmp_pkg::REGION_DECEL) begin
               state_in = tmp_pkg::S_VEL;
            end else begin
               state_in = tmp_pkg::S_DELTA;
            end
         end
         tmp_pkg::S_VEL:      if (status.iter_done) state_in = tmp_pkg::S_DELTA;
         tmp_pkg::S_DELTA:    if (status.iter_done) state_in = tmp_pkg::S_OUT;
         tmp_pkg::S_OUT:      if (slot_free) state_in = tmp_pkg::S_IDLE;
         default:             state_in = tmp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.step       = tmp_pkg::STEP_NONE;
      req_ready      = 1'b0;
      unique case (state_ff)
         tmp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tmp_pkg::S_ACCEL:    cmd.step = tmp_pkg::STEP_ACCEL;
         tmp_pkg::S_TRI_Q:    cmd.step = tmp_pkg::STEP_TRI_Q;
         tmp_pkg::S_TRI_ROOT: cmd.step = tmp_pkg::STEP_TRI_ROOT;
         tmp_pkg::S_TRI_PEAK: cmd.step = tmp_pkg::STEP_TRI_PEAK;
         tmp_pkg::S_CRUISE:   cmd.step = tmp_pkg::STEP_CRUISE;
         tmp_pkg::S_TICK:     cmd.set_static = 1'b1;
         tmp_pkg::S_VEL:      cmd.step = tmp_pkg::STEP_VEL;
         tmp_pkg::S_DELTA:    cmd.step = tmp_pkg::STEP_DELTA;
         tmp_pkg::S_OUT:      cmd.emit = slot_free;
         default:             cmd.step = tmp_pkg::STEP_NONE;
      endcase
   end

   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmp_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/tmp_datapath.sv =====
// ----------------------------------------------------------------------------
// tmp_datapath
// Profile state, phase decode, position integration and result word.
// ----------------------------------------------------------------------------
module tmp_datapath #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tmp_pkg::cmd_type                cmd,
   output tmp_pkg::status_type             status,
   input  logic                            req_operation,
   input  logic signed [31:0]              req_goal_position,
   input  logic signed [31:0]              req_start_position,
   input  logic [31:0]                     req_elapsed_ticks,
   input  logic                            csr_write,
   input  logic [tmp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tmp_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic signed [31:0]              rsp_setpoint_position,
   output logic [30:0]                     rsp_setpoint_velocity,
   output logic signed [47:0]              rsp_setpoint_accel,
   output logic                            rsp_profile_done
);

   localparam int unsigned TW = TIME_WIDTH;
   localparam int unsigned EW = TIME_WIDTH + 34;
   localparam logic [TW-1:0] TIME_MAX = '1;

   function automatic logic [TW-1:0] sat_time(input logic [EW-1:0] x);
      if (x > EW'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return x[TW-1:0];
   endfunction

   logic [30:0]        maxv_ff, maxv_in;
   logic [15:0]        rampt_ff, rampt_in;
   logic               op_ff, op_in;
   logic [31:0]        now_ff, now_in;
   logic [32:0]        dist_ff, dist_in;
   logic               dir_ff, dir_in;
   logic [46:0]        vt_ff, vt_in;
   logic signed [31:0] pos_ff, pos_in;
   logic [31:0]        prev_ff, prev_in;
   logic [30:0]        vel_ff, vel_in;
   logic [46:0]        accel_ff, accel_in;
   logic [TW-1:0]      ramp_end_ff, ramp_end_in;
   logic [TW-1:0]      cruise_end_ff, cruise_end_in;
   logic [TW-1:0]      total_ff, total_in;
   logic [30:0]        peak_ff, peak_in;
   logic [48:0]        tmp_ff, tmp_in;
   logic signed [31:0] out_pos_ff, out_pos_in;
   logic [30:0]        out_vel_ff, out_vel_in;
   logic signed [47:0] out_accel_ff, out_accel_in;
   logic               out_done_ff, out_done_in;

   logic [30:0]        v_eff;
   logic [15:0]        t_eff;
   logic [32:0]        diff;
   logic [EW-1:0]      now_e, ramp_e, cruise_e, total_e, dce;
   tmp_pkg::region_type region;
   logic [32:0]        dt;
   logic [32:0]        dt_mag;
   logic               alu_start;
   tmp_pkg::alu_op_type alu_op;
   logic [46:0]        alu_a;
   logic [48:0]        alu_b;
   logic               alu_done;
   logic [80:0]        alu_result;
   logic [47:0]        vel_ramp;
   logic [63:0]        dec_top;
   logic [63:0]        dec_diff;
   logic [40:0]        mag_c;
   logic signed [41:0] pos_w, mag_w, pos_sum;
   logic [EW-1:0]      ce_e, root_e;

   assign v_eff  = (maxv_ff == 31'd0) ? 31'd1 : maxv_ff;
   assign t_eff  = (rampt_ff == 16'd0) ? 16'd1 : rampt_ff;
   assign diff   = {req_goal_position[31], req_goal_position}
                 - {req_start_position[31], req_start_position};
   assign now_e    = EW'(now_ff);
   assign ramp_e   = EW'(ramp_end_ff);
   assign cruise_e = EW'(cruise_end_ff);
   assign total_e  = EW'(total_ff);
   assign dce      = now_e - cruise_e;
   assign dt       = {1'b0, now_ff} - {1'b0, prev_ff};
   assign dt_mag   = dt[32] ? (33'd0 - dt) : dt;

   always_comb begin
      if (now_e < ramp_e) begin
         region = tmp_pkg::REGION_RAMP;
      end else if (now_e < cruise_e) begin
         region = tmp_pkg::REGION_CRUISE;
      end else if (now_e < total_e) begin
         region = tmp_pkg::REGION_DECEL;
      end else begin
         region = tmp_pkg::REGION_OVER;
      end
   end

   assign status.iter_done  = alu_done;
   assign status.is_start   = (op_ff == tmp_pkg::OP_START);
   assign status.triangular = vt_ff > {14'd0, dist_ff};
   assign status.region     = region;

   always_comb begin
      alu_op = tmp_pkg::ALU_MUL;
      alu_a  = '0;
      alu_b  = '0;
      case (cmd.step)
         tmp_pkg::STEP_ACCEL: begin
            alu_op = tmp_pkg::ALU_DIV;
            alu_a  = {31'd0, t_eff};
            alu_b  = {2'b00, v_eff, 16'd0};
         end
         tmp_pkg::STEP_TRI_Q: begin
            alu_op = tmp_pkg::ALU_DIV;
            alu_a  = accel_ff;
            alu_b  = {dist_ff, 16'd0};
         end
         tmp_pkg::STEP_TRI_ROOT: begin
            alu_op = tmp_pkg::ALU_SQRT;
            alu_b  = tmp_ff;
         end
         tmp_pkg::STEP_TRI_PEAK: begin
            alu_a = accel_ff;
            alu_b = {24'd0, tmp_ff[24:0]};
         end
         tmp_pkg::STEP_CRUISE: begin
            alu_op = tmp_pkg::ALU_DIV;
            alu_a  = {16'd0, v_eff};
            alu_b  = {16'd0, dist_ff};
         end
         tmp_pkg::STEP_VEL: begin
            alu_a = accel_ff;
            alu_b = (region == tmp_pkg::REGION_RAMP) ? {17'd0, now_ff} : {16'd0, dce[32:0]};
         end
         tmp_pkg::STEP_DELTA: begin
            alu_a = {16'd0, vel_ff};
            alu_b = {16'd0, dt_mag};
         end
         default: alu_op = tmp_pkg::ALU_MUL;
      endcase
   end

   assign alu_start = (cmd.step != tmp_pkg::STEP_NONE);

   tmp_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_result)
   );

   assign vel_ramp = alu_result[63:16];
   assign dec_top  = {17'd0, peak_ff, 16'd0};
   assign dec_diff = dec_top - alu_result[63:0];
   assign mag_c    = (alu_result[63:0] > {23'd0, tmp_pkg::DELTA_CLAMP}) ?
                     tmp_pkg::DELTA_CLAMP : alu_result[40:0];
   assign pos_w    = {{10{pos_ff[31]}}, pos_ff};
   assign mag_w    = {1'b0, mag_c};
   assign pos_sum  = (dt[32] ^ dir_ff) ? (pos_w - mag_w) : (pos_w + mag_w);
   assign ce_e     = EW'(alu_result[32:0]);
   assign root_e   = EW'(alu_result[24:0]);

   always_comb begin
      maxv_in       = maxv_ff;
      rampt_in      = rampt_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      dist_in       = dist_ff;
      dir_in        = dir_ff;
      vt_in         = vt_ff;
      pos_in        = pos_ff;
      prev_in       = prev_ff;
      vel_in        = vel_ff;
      accel_in      = accel_ff;
      ramp_end_in   = ramp_end_ff;
      cruise_end_in = cruise_end_ff;
      total_in      = total_ff;
      peak_in       = peak_ff;
      tmp_in        = tmp_ff;
      out_pos_in    = out_pos_ff;
      out_vel_in    = out_vel_ff;
      out_accel_in  = out_accel_ff;
      out_done_in   = out_done_ff;

      if (csr_write) begin
         unique case (csr_index)
            tmp_pkg::CSR_MAX_VELOCITY: maxv_in  = csr_data[30:0];
            tmp_pkg::CSR_RAMP_TICKS:   rampt_in = csr_data[15:0];
            default:                   maxv_in  = maxv_ff;
         endcase
      end

      if (cmd.load) begin
         op_in  = req_operation;
         now_in = req_elapsed_ticks;
         if (req_operation == tmp_pkg::OP_START) begin
            dir_in  = diff[32];
            dist_in = diff[32] ? (33'd0 - diff) : diff;
            vt_in   = 47'(v_eff) * 47'(t_eff);
            pos_in  = req_start_position;
            prev_in = '0;
            vel_in  = '0;
         end
      end

      if (cmd.set_static) begin
         if (region == tmp_pkg::REGION_CRUISE) begin
            vel_in = peak_ff;
         end else if (region == tmp_pkg::REGION_OVER) begin
            vel_in = '0;
         end
      end

      if (alu_done) begin
         case (cmd.step)
            tmp_pkg::STEP_ACCEL: accel_in = alu_result[46:0];
            tmp_pkg::STEP_TRI_Q: tmp_in = alu_result[48:0];
            tmp_pkg::STEP_TRI_ROOT: begin
               tmp_in        = {24'd0, alu_result[24:0]};
               ramp_end_in   = sat_time(root_e);
               cruise_end_in = sat_time(root_e);
               total_in      = sat_time(root_e << 1);
            end
            tmp_pkg::STEP_TRI_PEAK: begin
               peak_in = (alu_result[63:16] > {17'd0, v_eff}) ? v_eff : alu_result[46:16];
            end
            tmp_pkg::STEP_CRUISE: begin
               ramp_end_in   = sat_time(EW'(t_eff));
               cruise_end_in = sat_time(ce_e);
               total_in      = sat_time(ce_e + EW'(t_eff));
               peak_in       = v_eff;
            end
            tmp_pkg::STEP_VEL: begin
               if (region == tmp_pkg::REGION_RAMP) begin
                  vel_in = (vel_ramp > {17'd0, peak_ff}) ? peak_ff : vel_ramp[30:0];
               end else begin
                  vel_in = (alu_result[63:0] >= dec_top) ? 31'd0 : dec_diff[46:16];
               end
            end
            tmp_pkg::STEP_DELTA: begin
               if (pos_sum > 42'sd2147483647) begin
                  pos_in = 32'sh7FFFFFFF;
               end else if (pos_sum < -42'sd2147483648) begin
                  pos_in = 32'sh80000000;
               end else begin
                  pos_in = pos_sum[31:0];
               end
               prev_in = now_ff;
            end
            default: tmp_in = tmp_ff;
         endcase
      end

      if (cmd.emit) begin
         out_pos_in = pos_ff;
         out_vel_in = vel_ff;
         if (op_ff == tmp_pkg::OP_START) begin
            out_accel_in = '0;
            out_done_in  = (total_ff == '0);
         end else begin
            case (region)
               tmp_pkg::REGION_RAMP:  out_accel_in = {1'b0, accel_ff};
               tmp_pkg::REGION_DECEL: out_accel_in = 48'sd0 - {1'b0, accel_ff};
               default:               out_accel_in = '0;
            endcase
            out_done_in = (region == tmp_pkg::REGION_OVER);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maxv_ff       <= tmp_pkg::MAX_VELOCITY_RESET;
         rampt_ff      <= tmp_pkg::RAMP_TICKS_RESET;
         dir_ff        <= 1'b0;
         pos_ff        <= '0;
         prev_ff       <= '0;
         vel_ff        <= '0;
         accel_ff      <= '0;
         ramp_end_ff   <= '0;
         cruise_end_ff <= '0;
         total_ff      <= '0;
         peak_ff       <= '0;
      end else begin
         maxv_ff       <= maxv_in;
         rampt_ff      <= rampt_in;
         dir_ff        <= dir_in;
         pos_ff        <= pos_in;
         prev_ff       <= prev_in;
         vel_ff        <= vel_in;
         accel_ff      <= accel_in;
         ramp_end_ff   <= ramp_end_in;
         cruise_end_ff <= cruise_end_in;
         total_ff      <= total_in;
         peak_ff       <= peak_in;
      end
      op_ff        <= op_in;
      now_ff       <= now_in;
      dist_ff      <= dist_in;
      vt_ff        <= vt_in;
      tmp_ff       <= tmp_in;
      out_pos_ff   <= out_pos_in;
      out_vel_ff   <= out_vel_in;
      out_accel_ff <= out_accel_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_setpoint_position = out_pos_ff;
   assign rsp_setpoint_velocity = out_vel_ff;
   assign rsp_setpoint_accel    = out_accel_ff;
   assign rsp_profile_done      = out_done_ff;

endmodule

// ===== sv/trapezoid_motion_profile.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_profile: one word in, one word out, one word at a time.
// Tick: one pass of the iterative unit (cruise/done) or two (ramp/decel).
// Start move: two divides (trapezoid), or divides, root and multiply (triangle).
// Synchronous reset clears profile state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "trapezoid_motion_profile_macros.svh"

module trapezoid_motion_profile #(
   parameter int unsigned TIME_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   tmp_req_if.sink   req_ch,
   tmp_rsp_if.source rsp_ch,
   tmp_csr_if.sink   csr_ch
);

   tmp_pkg::cmd_type    cmd;
   tmp_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   tmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tmp_datapath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_operation         (req_ch.operation),
      .req_goal_position     (req_ch.goal_position),
      .req_start_position    (req_ch.start_position),
      .req_elapsed_ticks     (req_ch.elapsed_ticks),
      .csr_write             (csr_ch.valid),
      .csr_index             (csr_ch.index),
      .csr_data              (csr_ch.data),
      .rsp_setpoint_position (rsp_ch.setpoint_position),
      .rsp_setpoint_velocity (rsp_ch.setpoint_velocity),
      .rsp_setpoint_accel    (rsp_ch.setpoint_accel),
      .rsp_profile_done      (rsp_ch.profile_done)
   );

   `TMP_ASSERT_NEXT(a_accept_busy, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `TMP_ASSERT_IMPLY(a_done_in_step, clock, reset, status.iter_done, cmd.step != tmp_pkg::STEP_NONE)
   `TMP_ASSERT_IMPLY(a_emit_slot, clock, reset, cmd.emit, !rsp_ch.valid || rsp_ch.ready)

endmodule
